// ===== rtl/ipd_pkg.sv =====
// Shared types and constants for the incremental PID duty controller.
`timescale 1ns / 1ps
package ipd_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned ERR_W   = DATA_W + 1;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned IN_W    = 2 * DATA_W;

	// Register indexes on the write port.
	localparam logic [IDX_W-1:0] REG_GAIN_P        = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I        = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D        = 3'd2;
	localparam logic [IDX_W-1:0] REG_ERR_BAND_HIGH = 3'd3;
	localparam logic [IDX_W-1:0] REG_ERR_BAND_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_MAX      = 3'd5;
	localparam logic [IDX_W-1:0] REG_DUTY_MIN      = 3'd6;

	localparam logic [DATA_W-1:0] ERR_BAND_HIGH_RST = 16'd1000;
	localparam logic [DATA_W-1:0] DUTY_MAX_RST      = 16'd1000;

	typedef struct packed {
		logic [DATA_W-1:0] gain_p;
		logic [DATA_W-1:0] gain_i;
		logic [DATA_W-1:0] gain_d;
		logic [DATA_W-1:0] err_band_high;
		logic [DATA_W-1:0] err_band_low;
		logic [DATA_W-1:0] duty_max;
		logic [DATA_W-1:0] duty_min;
	} ipd_cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] prev_error;
		logic signed [ERR_W-1:0] older_error;
		logic signed [ACC_W-1:0] accum_output;
		logic [DATA_W-1:0]       held_duty;
	} ipd_state_t;

endpackage

// ===== rtl/incremental_pid_duty.sv =====
// Top level of the incremental PID duty controller.
// Pipeline: input register, then result register, which loads once the output is free or taken.
// Throughput: one item per cycle while the output is not stalled; the loop state updates
// as an item leaves the input stage.
// While a result waits downstream the input register still takes one more item, then
// s_axis_tready drops until the result is taken.
// Reset (arst_n low, asynchronous) clears the loop state and held duty, empties both
// stages and loads the register defaults.
`timescale 1ns / 1ps
module incremental_pid_duty (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [ipd_pkg::IDX_W-1:0]   wr_index,
	input  logic [ipd_pkg::DATA_W-1:0]  wr_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [ipd_pkg::IN_W-1:0]    s_axis_tdata,   // [15:0] set_value, [31:16] feedback_value
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [ipd_pkg::DATA_W-1:0]  m_axis_tdata    // [15:0] duty
);
	import ipd_pkg::*;

	ipd_cfg_t          cfg;
	ipd_state_t        state_q;
	ipd_state_t        state_nxt;
	logic [DATA_W-1:0] set_s1;
	logic [DATA_W-1:0] fb_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;

	ipd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ipd_datapath u_dp (
		.set_value      (set_s1),
		.feedback_value (fb_s1),
		.cfg            (cfg),
		.state_cur      (state_q),
		.state_nxt      (state_nxt)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			set_s1 <= s_axis_tdata[DATA_W-1:0];
			fb_s1  <= s_axis_tdata[IN_W-1:DATA_W];
		end
	end

	// The held duty doubles as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = state_q.held_duty;

endmodule

// ===== rtl/ipd_cfg_regs.sv =====
// Configuration register bank of the incremental PID duty controller.
`timescale 1ns / 1ps
module ipd_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [ipd_pkg::IDX_W-1:0]  wr_index,
	input  logic [ipd_pkg::DATA_W-1:0] wr_data,
	output ipd_pkg::ipd_cfg_t        cfg
);
	import ipd_pkg::*;

	ipd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= '0;
			cfg_q.gain_i        <= '0;
			cfg_q.gain_d        <= '0;
			cfg_q.err_band_high <= ERR_BAND_HIGH_RST;
			cfg_q.err_band_low  <= '0;
			cfg_q.duty_max      <= DUTY_MAX_RST;
			cfg_q.duty_min      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN_P:        cfg_q.gain_p        <= wr_data;
				REG_GAIN_I:        cfg_q.gain_i        <= wr_data;
				REG_GAIN_D:        cfg_q.gain_d        <= wr_data;
				REG_ERR_BAND_HIGH: cfg_q.err_band_high <= wr_data;
				REG_ERR_BAND_LOW:  cfg_q.err_band_low  <= wr_data;
				REG_DUTY_MAX:      cfg_q.duty_max      <= wr_data;
				REG_DUTY_MIN:      cfg_q.duty_min      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ipd_datapath.sv =====
// Error banding, incremental PID step, saturation and duty clamp for one item.
`timescale 1ns / 1ps
module ipd_datapath (
	input  logic [ipd_pkg::DATA_W-1:0] set_value,
	input  logic [ipd_pkg::DATA_W-1:0] feedback_value,
	input  ipd_pkg::ipd_cfg_t          cfg,
	input  ipd_pkg::ipd_state_t        state_cur,
	output ipd_pkg::ipd_state_t        state_nxt
);
	import ipd_pkg::*;

	localparam int unsigned D1_W   = ERR_W + 1;
	localparam int unsigned D2_W   = ERR_W + 2;
	localparam int unsigned PROD_W = D2_W + DATA_W + 1;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam int unsigned NEXT_W = ACC_W + 2;

	logic signed [ERR_W-1:0]  err;
	logic signed [ERR_W-1:0]  hi_s;
	logic signed [ERR_W-1:0]  lo_s;
	logic signed [D1_W-1:0]   d_p;
	logic signed [D2_W-1:0]   d_d;
	logic signed [DATA_W:0]   kp_s;
	logic signed [DATA_W:0]   ki_s;
	logic signed [DATA_W:0]   kd_s;
	logic signed [PROD_W-1:0] prod_p;
	logic signed [PROD_W-1:0] prod_i;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_rnd;
	logic signed [NEXT_W-1:0] next_wide;
	logic signed [ACC_W-1:0]  next_sat;
	logic signed [ACC_W:0]    next_cmp;
	logic [DATA_W-1:0]        pid_duty;

	assign err  = $signed({1'b0, set_value}) - $signed({1'b0, feedback_value});
	assign hi_s = $signed({1'b0, cfg.err_band_high});
	assign lo_s = $signed({1'b0, cfg.err_band_low});

	assign kp_s = $signed({1'b0, cfg.gain_p});
	assign ki_s = $signed({1'b0, cfg.gain_i});
	assign kd_s = $signed({1'b0, cfg.gain_d});

	assign d_p = D1_W'(err) - D1_W'(state_cur.prev_error);
	assign d_d = D2_W'(err) - (D2_W'(state_cur.prev_error) <<< 1)
		+ D2_W'(state_cur.older_error);

	assign prod_p = PROD_W'(d_p) * PROD_W'(kp_s);
	assign prod_i = PROD_W'(err) * PROD_W'(ki_s);
	assign prod_d = PROD_W'(d_d) * PROD_W'(kd_s);

	assign sum     = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
	// Arithmetic shift gives floor, so adding half first rounds ties upward.
	assign sum_rnd = (sum + SUM_W'(128)) >>> 8;

	assign next_wide = NEXT_W'(state_cur.accum_output) + NEXT_W'(sum_rnd);

	always_comb begin
		if (next_wide[NEXT_W-1:ACC_W-1] == '0 || next_wide[NEXT_W-1:ACC_W-1] == '1) begin
			next_sat = next_wide[ACC_W-1:0];
		end else if (next_wide[NEXT_W-1]) begin
			next_sat = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			next_sat = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	assign next_cmp = (ACC_W+1)'(next_sat);

	// The minimum test wins when the limits cross.
	always_comb begin
		priority if (next_cmp < $signed({{(ACC_W+1-DATA_W){1'b0}}, cfg.duty_min})) begin
			pid_duty = cfg.duty_min;
		end else if (next_cmp > $signed({{(ACC_W+1-DATA_W){1'b0}}, cfg.duty_max})) begin
			pid_duty = cfg.duty_max;
		end else begin
			pid_duty = next_sat[DATA_W-1:0];
		end
	end

	always_comb begin
		state_nxt = state_cur;
		priority if (err > hi_s) begin
			state_nxt.held_duty = cfg.duty_max;
		end else if (err > lo_s && err < hi_s) begin
			state_nxt.older_error  = state_cur.prev_error;
			state_nxt.prev_error   = err;
			state_nxt.accum_output = next_sat;
			state_nxt.held_duty    = pid_duty;
		end else if (err < 0) begin
			state_nxt.held_duty = cfg.duty_min;
		end else begin
			state_nxt.held_duty = state_cur.held_duty;
		end
	end

endmodule
